@@ rtl/core/v2va_pkg.sv @@
// ----------------------------------------------------------------------------
// v2va_pkg
// Shared widths, flag bundle and CORDIC angle steps for vector_to_view_angles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package v2va_pkg;

    localparam int COORD_W          = 32;
    localparam int YAW_W            = 25;
    localparam int PITCH_W          = 26;
    localparam int CORDIC_STEPS_DEF = 20;
    localparam int ANGLE_FRAC_DEF   = 16;
    localparam int MAX_STEPS        = 32;
    localparam int SQ_W             = 64;
    localparam int ROOT_W           = 32;
    localparam int REM_W            = 35;
    localparam int K_W              = 5;
    localparam int STEP_W           = 40;
    localparam int STEP_FRAC        = 32;
    localparam int NORM_W           = 41;
    localparam int CORDIC_AW        = 45;
    localparam int CORDIC_ZW        = 41;
    localparam int ANG_MARGIN       = 10;
    localparam int DEG_MARGIN       = 11;

    localparam logic [63:0] RAD_TO_DEG_Q32 = 64'd246083499207;

    typedef struct packed {
        logic deg;
        logic xzero;
        logic xneg;
        logic ypos;
        logic yneg;
        logic zpos;
        logic zneg;
    } v2va_flags_t;

    function automatic logic [STEP_W-1:0] atan_deg_q32(input int unsigned i);
        logic [63:0] v;
        unique case (i)
            0:       v = 64'd193273528320;
            1:       v = 64'd114096026022;
            2:       v = 64'd60285206653;
            3:       v = 64'd30601712202;
            4:       v = 64'd15360239180;
            5:       v = 64'd7687607525;
            6:       v = 64'd3844741810;
            7:       v = 64'd1922488225;
            8:       v = 64'd961258780;
            9:       v = 64'd480631223;
            10:      v = 64'd240315840;
            11:      v = 64'd120157949;
            12:      v = 64'd60078978;
            13:      v = 64'd30039490;
            14:      v = 64'd15019743;
            15:      v = 64'd7509872;
            default: v = (RAD_TO_DEG_Q32 + (64'd1 << (i - 1))) >> i;
        endcase
        return v[STEP_W-1:0];
    endfunction

endpackage

@@ rtl/core/v2va_if.sv @@
// ----------------------------------------------------------------------------
// v2va_vec_if / v2va_ang_if
// Valid/ready channels for direction vectors and view angles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface v2va_vec_if;
    logic                                valid;
    logic                                ready;
    logic signed [v2va_pkg::COORD_W-1:0] x_coord;
    logic signed [v2va_pkg::COORD_W-1:0] y_coord;
    logic signed [v2va_pkg::COORD_W-1:0] z_coord;

    modport source (output valid, x_coord, y_coord, z_coord, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface v2va_ang_if;
    logic                                valid;
    logic                                ready;
    logic        [v2va_pkg::YAW_W-1:0]   yaw_angle;
    logic signed [v2va_pkg::PITCH_W-1:0] pitch_angle;

    modport source (output valid, yaw_angle, pitch_angle, input ready);
    modport sink   (input valid, yaw_angle, pitch_angle, output ready);
endinterface

@@ rtl/core/v2va_cordic.sv @@
// ----------------------------------------------------------------------------
// v2va_cordic
// Pipelined CORDIC vectoring unit: atan2(+-mb, ma) in rounded degrees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v2va_cordic #(
    parameter int STEPS = v2va_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC  = v2va_pkg::ANGLE_FRAC_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    adv,
    input  logic                                    src_valid,
    input  logic [v2va_pkg::SQ_W-1:0]               ma,
    input  logic [v2va_pkg::SQ_W-1:0]               mb,
    input  logic                                    bneg,
    input  v2va_pkg::v2va_flags_t                   src_flags,
    output logic                                    res_valid,
    output logic signed [FRAC+v2va_pkg::ANG_MARGIN-1:0] angle,
    output v2va_pkg::v2va_flags_t                   res_flags
);
    import v2va_pkg::*;

    localparam int NST   = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;
    localparam int SH    = STEP_FRAC - FRAC;
    localparam int ANG_W = FRAC + ANG_MARGIN;
    localparam int AW    = CORDIC_AW;
    localparam int ZW    = CORDIC_ZW;
    localparam logic signed [ZW-1:0] HALF = ZW'(64'd1 << (SH - 1));

    typedef struct packed {
        logic [SQ_W-1:0] ma;
        logic [SQ_W-1:0] mb;
        logic [SQ_W-1:0] m;
        logic            bneg;
        logic            zero;
        v2va_flags_t     f;
    } nrm_t;

    typedef struct packed {
        logic [NORM_W-1:0] ma;
        logic [NORM_W-1:0] mb;
        logic              bneg;
        logic              zero;
        v2va_flags_t       f;
    } n2_t;

    typedef struct packed {
        logic signed [AW-1:0] a;
        logic signed [AW-1:0] b;
        logic signed [ZW-1:0] z;
        logic                 zero;
        v2va_flags_t          f;
    } it_t;

    function automatic nrm_t nrm_step(input nrm_t v, input int unsigned w);
        nrm_t r;
        r = v;
        if ((v.m >> (SQ_W - w)) == '0)
        begin
            r.m  = v.m << w;
            r.ma = v.ma << w;
            r.mb = v.mb << w;
        end
        return r;
    endfunction

    nrm_t                    n0_reg, n0_next, n1_reg, n1_next, n2_tmp;
    n2_t                     n2_reg, n2_next;
    it_t                     it0_next;
    it_t                     it_reg   [NST+1];
    logic                    it_v_reg [NST+1];
    logic                    n0_v_reg, n1_v_reg, n2_v_reg, r_v_reg;
    logic signed [ZW-1:0]    zsum;
    logic signed [ZW-1:0]    zrnd;
    logic signed [ANG_W-1:0] ang_reg, ang_next;
    v2va_flags_t             fl_reg;

    always_comb
    begin
        n0_next.ma   = ma;
        n0_next.mb   = mb;
        n0_next.m    = (ma > mb) ? ma : mb;
        n0_next.bneg = bneg;
        n0_next.zero = (mb == '0);
        n0_next.f    = src_flags;
    end

    always_comb
    begin
        n1_next = nrm_step(nrm_step(nrm_step(n0_reg, 32), 16), 8);
    end

    always_comb
    begin
        n2_tmp       = nrm_step(nrm_step(nrm_step(n1_reg, 4), 2), 1);
        n2_next.ma   = n2_tmp.ma[SQ_W-1 -: NORM_W];
        n2_next.mb   = n2_tmp.mb[SQ_W-1 -: NORM_W];
        n2_next.bneg = n2_tmp.bneg;
        n2_next.zero = n2_tmp.zero;
        n2_next.f    = n2_tmp.f;
    end

    always_comb
    begin
        it0_next.a    = signed'(AW'(n2_reg.ma));
        it0_next.b    = n2_reg.bneg ? -signed'(AW'(n2_reg.mb)) : signed'(AW'(n2_reg.mb));
        it0_next.z    = '0;
        it0_next.zero = n2_reg.zero;
        it0_next.f    = n2_reg.f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n0_v_reg    <= 1'b0;
            n1_v_reg    <= 1'b0;
            n2_v_reg    <= 1'b0;
            it_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            n0_v_reg    <= src_valid;
            n1_v_reg    <= n0_v_reg;
            n2_v_reg    <= n1_v_reg;
            it_v_reg[0] <= n2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n0_reg    <= n0_next;
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            it_reg[0] <= it0_next;
        end
    end

    for (genvar i = 0; i < NST; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ANG = ZW'(atan_deg_q32(i));
        it_t                  it_next;
        logic signed [AW-1:0] da, db;

        always_comb
        begin
            da      = it_reg[i].b >>> i;
            db      = it_reg[i].a >>> i;
            it_next = it_reg[i];
            if (!it_reg[i].b[AW-1])
            begin
                it_next.a = it_reg[i].a + da;
                it_next.b = it_reg[i].b - db;
                it_next.z = it_reg[i].z + ANG;
            end
            else
            begin
                it_next.a = it_reg[i].a - da;
                it_next.b = it_reg[i].b + db;
                it_next.z = it_reg[i].z - ANG;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                it_v_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                it_v_reg[i+1] <= it_v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                it_reg[i+1] <= it_next;
            end
        end
    end

    always_comb
    begin
        zsum     = it_reg[NST].z + HALF;
        zrnd     = zsum >>> SH;
        ang_next = it_reg[NST].zero ? '0 : ANG_W'(zrnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_v_reg <= it_v_reg[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_reg <= ang_next;
            fl_reg  <= it_reg[NST].f;
        end
    end

    assign res_valid = r_v_reg;
    assign angle     = ang_reg;
    assign res_flags = fl_reg;

endmodule

@@ rtl/core/vector_to_view_angles.sv @@
// ----------------------------------------------------------------------------
// vector_to_view_angles
// The path from input transfer to valid result runs through the 32-stage square root
//   and the CORDIC (CORDIC_STEPS capped at 32).
// Throughput: one vector per cycle; every stage advances unless a held result
//   is not taken. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_to_view_angles #(
    parameter int CORDIC_STEPS    = v2va_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = v2va_pkg::ANGLE_FRAC_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    v2va_vec_if.sink  vec,
    v2va_ang_if.source ang
);
    import v2va_pkg::*;

    localparam int ANG_W = ANGLE_FRAC_BITS + ANG_MARGIN;
    localparam int D_W   = (ANGLE_FRAC_BITS + DEG_MARGIN > PITCH_W) ?
                           ANGLE_FRAC_BITS + DEG_MARGIN : PITCH_W;
    localparam logic signed [D_W-1:0] DEG90  = D_W'(64'd90 << ANGLE_FRAC_BITS);
    localparam logic signed [D_W-1:0] DEG180 = D_W'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic signed [D_W-1:0] DEG270 = D_W'(64'd270 << ANGLE_FRAC_BITS);
    localparam logic signed [D_W-1:0] DEG360 = D_W'(64'd360 << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] az;
        v2va_flags_t        f;
    } abs_t;

    typedef struct packed {
        logic [SQ_W-1:0]    sqx;
        logic [SQ_W-1:0]    sqy;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] az;
        v2va_flags_t        f;
    } sq_t;

    typedef struct packed {
        logic [SQ_W-1:0]    s;
        logic [K_W-1:0]     k;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] az;
        v2va_flags_t        f;
    } snrm_t;

    typedef struct packed {
        logic [SQ_W-1:0]    n;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] az;
        logic [K_W-1:0]     k;
        v2va_flags_t        f;
    } sqs_t;

    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic [SQ_W-1:0]    mbp;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        v2va_flags_t        f;
    } hand_t;

    function automatic snrm_t s_norm(input snrm_t v, input int unsigned w);
        snrm_t r;
        r = v;
        if ((v.s >> (SQ_W - w)) == '0)
        begin
            r.s = v.s << w;
            r.k = v.k + K_W'(w >> 1);
        end
        return r;
    endfunction

    logic                        adv;
    logic                        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, h_v_reg;
    logic                        f1_v_reg, f2_v_reg, o_v_reg;
    logic signed [COORD_W-1:0]   x1_reg, y1_reg, z1_reg;
    abs_t                        p2_reg, p2_next;
    sq_t                         p3_reg, p3_next;
    snrm_t                       p4_reg, p4_next, p5_reg, p5_next, p6_reg, p6_next;
    sqs_t                        sq_reg   [ROOT_W];
    logic                        sq_v_reg [ROOT_W];
    hand_t                       h_reg, h_next;
    logic                        y_valid, p_valid;
    logic signed [ANG_W-1:0]     y_ang, p_ang;
    v2va_flags_t                 y_flags, p_flags;
    logic signed [D_W-1:0]       yaw1_reg, yaw1_next, pit1_reg, pit1_next;
    logic signed [D_W-1:0]       yaw2_reg, yaw2_next, pit2_reg, pit2_next;
    logic signed [D_W-1:0]       pit_neg;
    logic [YAW_W-1:0]            yaw_reg;
    logic signed [PITCH_W-1:0]   pitch_reg;

    assign adv       = !o_v_reg || ang.ready;
    assign vec.ready = adv;

    always_comb
    begin
        p2_next.ax      = x1_reg[COORD_W-1] ? COORD_W'(-x1_reg) : COORD_W'(x1_reg);
        p2_next.ay      = y1_reg[COORD_W-1] ? COORD_W'(-y1_reg) : COORD_W'(y1_reg);
        p2_next.az      = z1_reg[COORD_W-1] ? COORD_W'(-z1_reg) : COORD_W'(z1_reg);
        p2_next.f.deg   = (x1_reg == '0) && (y1_reg == '0);
        p2_next.f.xzero = (x1_reg == '0);
        p2_next.f.xneg  = x1_reg[COORD_W-1];
        p2_next.f.ypos  = !y1_reg[COORD_W-1] && (y1_reg != '0);
        p2_next.f.yneg  = y1_reg[COORD_W-1];
        p2_next.f.zpos  = !z1_reg[COORD_W-1] && (z1_reg != '0);
        p2_next.f.zneg  = z1_reg[COORD_W-1];
    end

    always_comb
    begin
        p3_next.sqx = SQ_W'(p2_reg.ax) * SQ_W'(p2_reg.ax);
        p3_next.sqy = SQ_W'(p2_reg.ay) * SQ_W'(p2_reg.ay);
        p3_next.ax  = p2_reg.ax;
        p3_next.ay  = p2_reg.ay;
        p3_next.az  = p2_reg.az;
        p3_next.f   = p2_reg.f;
    end

    always_comb
    begin
        p4_next.s  = p3_reg.sqx + p3_reg.sqy;
        p4_next.k  = '0;
        p4_next.ax = p3_reg.ax;
        p4_next.ay = p3_reg.ay;
        p4_next.az = p3_reg.az;
        p4_next.f  = p3_reg.f;
    end

    always_comb
    begin
        p5_next = s_norm(s_norm(s_norm(p4_reg, 32), 16), 8);
        p6_next = s_norm(s_norm(p5_reg, 4), 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= vec.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= vec.x_coord;
            y1_reg <= vec.y_coord;
            z1_reg <= vec.z_coord;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
            p5_reg <= p5_next;
            p6_reg <= p6_next;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        sqs_t             src, sq_next;
        logic             src_v;
        logic [REM_W-1:0] rem_sh, trial;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                src.n    = p6_reg.s;
                src.rem  = '0;
                src.root = '0;
                src.ax   = p6_reg.ax;
                src.ay   = p6_reg.ay;
                src.az   = p6_reg.az;
                src.k    = p6_reg.k;
                src.f    = p6_reg.f;
                src_v    = v6_reg;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                src   = sq_reg[j-1];
                src_v = sq_v_reg[j-1];
            end
        end

        always_comb
        begin
            rem_sh  = {src.rem[REM_W-3:0], src.n[2*(ROOT_W-1-j)+1 -: 2]};
            trial   = REM_W'({src.root, 2'b01});
            sq_next = src;
            if (rem_sh >= trial)
            begin
                sq_next.rem  = rem_sh - trial;
                sq_next.root = {src.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_next.rem  = rem_sh;
                sq_next.root = {src.root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[j] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[j] <= sq_next;
            end
        end
    end

    always_comb
    begin
        h_next.root = sq_reg[ROOT_W-1].root;
        h_next.mbp  = SQ_W'(sq_reg[ROOT_W-1].az) << sq_reg[ROOT_W-1].k;
        h_next.ax   = sq_reg[ROOT_W-1].ax;
        h_next.ay   = sq_reg[ROOT_W-1].ay;
        h_next.f    = sq_reg[ROOT_W-1].f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            h_v_reg <= sq_v_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg <= h_next;
        end
    end

    v2va_cordic #(
        .STEPS (CORDIC_STEPS),
        .FRAC  (ANGLE_FRAC_BITS)
    ) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .src_valid (h_v_reg),
        .ma        (SQ_W'(h_reg.ax)),
        .mb        (SQ_W'(h_reg.ay)),
        .bneg      (h_reg.f.xneg ? h_reg.f.ypos : h_reg.f.yneg),
        .src_flags (h_reg.f),
        .res_valid (y_valid),
        .angle     (y_ang),
        .res_flags (y_flags)
    );

    v2va_cordic #(
        .STEPS (CORDIC_STEPS),
        .FRAC  (ANGLE_FRAC_BITS)
    ) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .src_valid (h_v_reg),
        .ma        (SQ_W'(h_reg.root)),
        .mb        (h_reg.mbp),
        .bneg      (h_reg.f.zneg),
        .src_flags (h_reg.f),
        .res_valid (p_valid),
        .angle     (p_ang),
        .res_flags (p_flags)
    );

    always_comb
    begin
        priority if (y_flags.deg)
        begin
            yaw1_next = '0;
        end
        else if (y_flags.xzero)
        begin
            yaw1_next = y_flags.ypos ? DEG90 : DEG270;
        end
        else if (y_flags.xneg)
        begin
            yaw1_next = D_W'(y_ang) + DEG180;
        end
        else
        begin
            yaw1_next = D_W'(y_ang);
        end

        if (p_flags.deg)
        begin
            pit1_next = p_flags.zpos ? DEG90 : DEG270;
        end
        else
        begin
            pit1_next = D_W'(p_ang);
        end
    end

    always_comb
    begin
        priority if (yaw1_reg < 0)
        begin
            yaw2_next = yaw1_reg + DEG360;
        end
        else if (yaw1_reg >= DEG360)
        begin
            yaw2_next = yaw1_reg - DEG360;
        end
        else
        begin
            yaw2_next = yaw1_reg;
        end

        priority if (pit1_reg < 0)
        begin
            pit2_next = pit1_reg + DEG360;
        end
        else if (pit1_reg >= DEG360)
        begin
            pit2_next = pit1_reg - DEG360;
        end
        else
        begin
            pit2_next = pit1_reg;
        end

        pit_neg = -pit2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else if (adv)
        begin
            f1_v_reg <= y_valid && p_valid;
            f2_v_reg <= f1_v_reg;
            o_v_reg  <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yaw1_reg  <= yaw1_next;
            pit1_reg  <= pit1_next;
            yaw2_reg  <= yaw2_next;
            pit2_reg  <= pit2_next;
            yaw_reg   <= yaw2_reg[YAW_W-1:0];
            pitch_reg <= pit_neg[PITCH_W-1:0];
        end
    end

    assign ang.valid       = o_v_reg;
    assign ang.yaw_angle   = yaw_reg;
    assign ang.pitch_angle = pitch_reg;

endmodule
